### rtl/ntfsdr_pkg.sv
// Shared types, constants and helpers of the data run list decoder.
// No dependencies; every other source file but ntfsdr_if imports this package.
package ntfsdr_pkg;

   localparam int MAX_FIELD_BYTES = 8;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_OFFSET  = 2'd2,
      PH_STOPPED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RUN   = 2'd0,
      KIND_END   = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] cluster_count;
      logic [63:0] start_cluster;
      logic        sparse;
      logic        list_done;
   } rsp_item_type;

   // Upper bits to set when sign extending an offset field of nbytes bytes.
   function automatic logic [63:0] ext_mask(input logic [3:0] nbytes);
      logic [63:0] mask;
      case (nbytes)
         4'd1:    mask = 64'hFFFF_FFFF_FFFF_FF00;
         4'd2:    mask = 64'hFFFF_FFFF_FFFF_0000;
         4'd3:    mask = 64'hFFFF_FFFF_FF00_0000;
         4'd4:    mask = 64'hFFFF_FFFF_0000_0000;
         4'd5:    mask = 64'hFFFF_FF00_0000_0000;
         4'd6:    mask = 64'hFFFF_0000_0000_0000;
         4'd7:    mask = 64'hFF00_0000_0000_0000;
         default: mask = 64'h0;
      endcase
      return mask;
   endfunction

endpackage

### rtl/ntfsdr_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on nothing.
interface ntfsdr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ntfsdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] cluster_count;
   logic [63:0] start_cluster;
   logic        sparse;
   logic        list_done;

   modport source (output valid, output kind, output cluster_count, output start_cluster,
                   output sparse, output list_done, input ready);
   modport sink (input valid, input kind, input cluster_count, input start_cluster,
                 input sparse, input list_done, output ready);
endinterface

### rtl/ntfsdr_in_reg.sv
// Input register: captures one request transaction and holds it until used.
// Depends on ntfsdr_pkg and ntfsdr_req_if.
module ntfsdr_in_reg
   import ntfsdr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ntfsdr_req_if.sink        req_chan,
   input  logic              advance,
   output logic              item_valid,
   output req_item_type      item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{data_byte: req_chan.data_byte, buffer_end: req_chan.buffer_end};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/ntfsdr_parser.sv
// Run list parser: phase machine, field gathering and running cluster add.
// Depends on ntfsdr_pkg.
module ntfsdr_parser
   import ntfsdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output logic         res_valid,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  len_bytes_ff, len_bytes_in;
   logic [3:0]  off_bytes_ff, off_bytes_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [63:0] count_acc_ff, count_acc_in;
   logic [63:0] offset_acc_ff, offset_acc_in;
   logic [63:0] cluster_ff, cluster_in;

   logic [7:0]  b;
   logic        last;
   logic [3:0]  ls, os;
   logic        hdr_zero, hdr_bad;
   logic [3:0]  pos_inc;
   logic [63:0] lane;
   logic [63:0] count_new, offset_new, offset_ext, cluster_sum;
   logic        len_full, off_full;

   assign b          = item.data_byte;
   assign last       = item.buffer_end;
   assign ls         = b[3:0];
   assign os         = b[7:4];
   assign hdr_zero   = (b == 8'd0);
   assign hdr_bad    = (ls == 4'd0) || (ls > 4'(MAX_FIELD_BYTES)) || (os > 4'(MAX_FIELD_BYTES));
   assign pos_inc    = {1'b0, byte_pos_ff} + 4'd1;
   assign lane       = {56'd0, b} << {byte_pos_ff, 3'd0};
   assign count_new  = count_acc_ff | lane;
   assign offset_new = offset_acc_ff | lane;
   assign offset_ext = offset_new | (b[7] ? ext_mask(off_bytes_ff) : 64'd0);
   assign cluster_sum = cluster_ff + offset_ext;
   assign len_full   = (pos_inc >= len_bytes_ff);
   assign off_full   = (pos_inc >= off_bytes_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_zero || hdr_bad || last) begin
                  phase_in = PH_STOPPED;
               end else begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (len_full && (off_bytes_ff == 4'd0)) begin
                  phase_in = PH_HEADER;
               end else if (last) begin
                  phase_in = PH_STOPPED;
               end else if (len_full) begin
                  phase_in = PH_OFFSET;
               end
            end
            PH_OFFSET: begin
               if (off_full) begin
                  phase_in = PH_HEADER;
               end else if (last) begin
                  phase_in = PH_STOPPED;
               end
            end
            PH_STOPPED: phase_in = PH_STOPPED;
            default:    phase_in = PH_STOPPED;
         endcase
         if (last) begin
            phase_in = PH_HEADER;
         end
      end
   end

   // result and datapath
   always_comb begin
      res_valid     = 1'b0;
      result        = '{kind: KIND_RUN, cluster_count: 64'd0, start_cluster: 64'd0,
                        sparse: 1'b0, list_done: 1'b0};
      len_bytes_in  = len_bytes_ff;
      off_bytes_in  = off_bytes_ff;
      byte_pos_in   = byte_pos_ff;
      count_acc_in  = count_acc_ff;
      offset_acc_in = offset_acc_ff;
      cluster_in    = cluster_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_zero) begin
                  res_valid        = 1'b1;
                  result.kind      = KIND_END;
                  result.list_done = 1'b1;
               end else if (hdr_bad) begin
                  res_valid        = 1'b1;
                  result.kind      = KIND_BAD;
                  result.list_done = 1'b1;
               end else if (last) begin
                  res_valid        = 1'b1;
                  result.kind      = KIND_TRUNC;
                  result.list_done = 1'b1;
               end else begin
                  len_bytes_in  = ls;
                  off_bytes_in  = os;
                  byte_pos_in   = 3'd0;
                  count_acc_in  = 64'd0;
                  offset_acc_in = 64'd0;
               end
            end
            PH_LENGTH: begin
               count_acc_in = count_new;
               byte_pos_in  = pos_inc[2:0];
               if (len_full && (off_bytes_ff == 4'd0)) begin
                  res_valid            = 1'b1;
                  result.cluster_count = count_new;
                  result.sparse        = 1'b1;
                  result.list_done     = last;
               end else if (last) begin
                  res_valid        = 1'b1;
                  result.kind      = KIND_TRUNC;
                  result.list_done = 1'b1;
               end else if (len_full) begin
                  byte_pos_in = 3'd0;
               end
            end
            PH_OFFSET: begin
               offset_acc_in = offset_new;
               byte_pos_in   = pos_inc[2:0];
               if (off_full) begin
                  cluster_in           = cluster_sum;
                  res_valid            = 1'b1;
                  result.cluster_count = count_acc_ff;
                  result.start_cluster = cluster_sum;
                  result.list_done     = last;
               end else if (last) begin
                  res_valid        = 1'b1;
                  result.kind      = KIND_TRUNC;
                  result.list_done = 1'b1;
               end
            end
            PH_STOPPED: begin
               res_valid = 1'b0;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
         if (last) begin
            cluster_in = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         cluster_ff <= 64'd0;
      end else begin
         phase_ff   <= phase_in;
         cluster_ff <= cluster_in;
      end
   end

   always_ff @(posedge clock) begin
      len_bytes_ff  <= len_bytes_in;
      off_bytes_ff  <= off_bytes_in;
      byte_pos_ff   <= byte_pos_in;
      count_acc_ff  <= count_acc_in;
      offset_acc_ff <= offset_acc_in;
   end

endmodule

### rtl/ntfsdr_out_reg.sv
// Output register: holds one response transaction until the sink takes it.
// Depends on ntfsdr_pkg and ntfsdr_rsp_if.
module ntfsdr_out_reg
   import ntfsdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   input  rsp_item_type result,
   output logic         out_free,
   ntfsdr_rsp_if.source rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         item_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = item_ff.kind;
   assign rsp_chan.cluster_count = item_ff.cluster_count;
   assign rsp_chan.start_cluster = item_ff.start_cluster;
   assign rsp_chan.sparse        = item_ff.sparse;
   assign rsp_chan.list_done     = item_ff.list_done;

endmodule

### rtl/ntfs_data_run_decoder_unit.sv
// Top level of the data run list decoder: input register, parser, output register.
// Depends on ntfsdr_pkg, ntfsdr_if, ntfsdr_in_reg, ntfsdr_parser, ntfsdr_out_reg.
//
//   channel    direction  payload
//   req_chan   in         data_byte[7:0], buffer_end
//   rsp_chan   out        kind[1:0], cluster_count[63:0], start_cluster[63:0],
//                         sparse, list_done
//
// One byte per cycle sustained while responses are taken; a byte is taken into the input
// register, passed through the parser and its result held in the output register.
// Synchronous reset returns the parser to awaiting a header with a zero cluster base.
// A stalled response holds the output register; the input register then fills and
// req_chan.ready drops until the response is taken.
module ntfs_data_run_decoder_unit
   import ntfsdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ntfsdr_req_if.sink   req_chan,
   ntfsdr_rsp_if.source rsp_chan
);

   logic         item_valid;
   req_item_type item;
   logic         out_free;
   logic         fire;
   logic         res_valid;
   rsp_item_type result;

   assign fire = item_valid && out_free;

   ntfsdr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   ntfsdr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .result    (result)
   );

   ntfsdr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .result    (result),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

### rtl/ntfsdr_checker.sv
// Port-level checks of the decoder, bound to the top level.
// Depends on ntfsdr_pkg and ntfs_data_run_decoder_unit.
module ntfsdr_checker
   import ntfsdr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [63:0] rsp_cluster_count,
   input logic [63:0] rsp_start_cluster,
   input logic        rsp_sparse,
   input logic        rsp_list_done
);

   // hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_cluster_count) && $stable(rsp_start_cluster)
         && $stable(rsp_sparse) && $stable(rsp_list_done))
      else $error("response changed while stalled");

   a_stop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_RUN) |-> rsp_list_done && !rsp_sparse
         && (rsp_cluster_count == 64'd0) && (rsp_start_cluster == 64'd0))
      else $error("stop transaction carries run fields");

   a_sparse_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sparse |-> (rsp_kind == KIND_RUN) && (rsp_start_cluster == 64'd0))
      else $error("sparse run with nonzero start");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind ntfs_data_run_decoder_unit ntfsdr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_cluster_count (rsp_chan.cluster_count),
   .rsp_start_cluster (rsp_chan.start_cluster),
   .rsp_sparse        (rsp_chan.sparse),
   .rsp_list_done     (rsp_chan.list_done)
);

### tb/sv/tb_ntfs_data_run_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of ntfs_data_run_decoder_unit: byte streams of data run lists in,
// decoded run transactions checked against an in-bench decoder of the run list format.
// Depends on ntfsdr_pkg, ntfsdr_if and the RTL of the decoder.
module tb_ntfs_data_run_decoder_unit;
   import ntfsdr_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_BYTES = 1050;
   localparam int HOLD_AFTER   = 200;
   localparam int HOLD_CYCLES  = 80;
   localparam int PRINT_CAP    = 100;

   typedef enum int {FLOW_STEADY, FLOW_RANDOM, FLOW_SLOW, FLOW_PATTERN} flow_type;

   typedef struct {
      req_item_type item;
      bit           drain_first;
   } pending_type;

   logic clock;
   logic reset;

   ntfsdr_req_if req_bus();
   ntfsdr_rsp_if rsp_bus();

   ntfs_data_run_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   pending_type  pending_bytes[$];
   rsp_item_type expected_runs[$];
   int           fail_count   = 0;
   int           results_seen = 0;

   // decoder state
   phase_type   prs_phase  = PH_HEADER;
   logic [3:0]  prs_len    = '0;
   logic [3:0]  prs_off    = '0;
   logic [3:0]  prs_pos    = '0;
   logic [63:0] prs_count  = '0;
   logic [63:0] prs_offset = '0;
   logic [63:0] prs_base   = '0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic rsp_item_type stop_item(input kind_type k);
      rsp_item_type r;
      r = '0;
      r.kind = k;
      r.list_done = 1'b1;
      return r;
   endfunction

   function automatic void decode_run_byte(input logic [7:0] b, input logic last);
      rsp_item_type r;
      logic         hit;
      logic [3:0]   ls;
      logic [3:0]   os;
      logic [63:0]  delta;
      int           nbits;
      r   = '0;
      hit = 1'b0;
      ls  = b[3:0];
      os  = b[7:4];
      case (prs_phase)
         PH_HEADER: begin
            hit = 1'b1;
            if (b == 8'h00) begin
               r = stop_item(KIND_END);
               prs_phase = PH_STOPPED;
            end else if (ls == 0 || ls > MAX_FIELD_BYTES || os > MAX_FIELD_BYTES) begin
               r = stop_item(KIND_BAD);
               prs_phase = PH_STOPPED;
            end else if (last) begin
               r = stop_item(KIND_TRUNC);
               prs_phase = PH_STOPPED;
            end else begin
               hit = 1'b0;
               prs_len = ls;
               prs_off = os;
               prs_pos = '0;
               prs_count = '0;
               prs_offset = '0;
               prs_phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            prs_count = prs_count | (64'(b) << (8 * prs_pos[2:0]));
            prs_pos = prs_pos + 4'd1;
            if (prs_pos >= prs_len) begin
               if (prs_off == 4'd0) begin
                  hit = 1'b1;
                  r.kind = KIND_RUN;
                  r.cluster_count = prs_count;
                  r.sparse = 1'b1;
                  r.list_done = last;
                  prs_phase = PH_HEADER;
               end else if (last) begin
                  hit = 1'b1;
                  r = stop_item(KIND_TRUNC);
                  prs_phase = PH_STOPPED;
               end else begin
                  prs_pos = '0;
                  prs_phase = PH_OFFSET;
               end
            end else if (last) begin
               hit = 1'b1;
               r = stop_item(KIND_TRUNC);
               prs_phase = PH_STOPPED;
            end
         end
         PH_OFFSET: begin
            prs_offset = prs_offset | (64'(b) << (8 * prs_pos[2:0]));
            prs_pos = prs_pos + 4'd1;
            if (prs_pos >= prs_off) begin
               delta = prs_offset;
               nbits = 8 * prs_off;
               // extend the sign of short offsets; a full-width offset stands as it is
               if (prs_off < 4'd8 && delta[nbits - 1])
                  delta = delta | (~64'd0 << nbits);
               prs_base = prs_base + delta;
               hit = 1'b1;
               r.kind = KIND_RUN;
               r.cluster_count = prs_count;
               r.start_cluster = prs_base;
               r.list_done = last;
               prs_phase = PH_HEADER;
            end else if (last) begin
               hit = 1'b1;
               r = stop_item(KIND_TRUNC);
               prs_phase = PH_STOPPED;
            end
         end
         default: prs_phase = PH_STOPPED;
      endcase
      if (hit)
         expected_runs.insert(expected_runs.size(), r);
      if (last) begin
         prs_phase = PH_HEADER;
         prs_len = '0;
         prs_off = '0;
         prs_pos = '0;
         prs_count = '0;
         prs_offset = '0;
         prs_base = '0;
      end
   endfunction

   function automatic void check_field(input string label, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last, input bit drain = 1'b0);
      pending_type p;
      p.item.data_byte = b;
      p.item.buffer_end = last;
      p.drain_first = drain;
      pending_bytes.insert(pending_bytes.size(), p);
   endtask

   task automatic add_random_buffer(input bit drain);
      logic [7:0] bytes[$];
      logic [7:0] b;
      int         runs;
      int         ls;
      int         os;
      int         cut;
      runs = $urandom_range(0, 5);
      for (int r = 0; r < runs; r++) begin
         ls = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         case ($urandom_range(0, 5))
            0:       os = 0;
            1:       os = $urandom_range(5, 8);
            default: os = $urandom_range(1, 4);
         endcase
         bytes.insert(bytes.size(), {os[3:0], ls[3:0]});
         repeat (ls + os) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            bytes.insert(bytes.size(), 8'h00);
            repeat ($urandom_range(0, 3)) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
         end
         10, 11, 12, 13, 14: begin
            if (bytes.size() == 0)
               bytes.insert(bytes.size(), 8'h00);
         end
         15, 16, 17: begin
            if (bytes.size() == 0) begin
               bytes.insert(bytes.size(),
                            {4'($urandom_range(0, 8)), 4'($urandom_range(1, 8))});
            end else begin
               cut = $urandom_range(1, bytes.size());
               while (bytes.size() > cut) void'(bytes.pop_back());
            end
         end
         18: begin
            case ($urandom_range(0, 2))
               0:       b = {4'($urandom_range(0, 15)), 4'h0};
               1:       b = {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
               default: b = {4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))};
            endcase
            bytes.insert(bytes.size(), b);
            repeat ($urandom_range(0, 2)) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
         end
         default: begin
            repeat ($urandom_range(1, 6)) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
         end
      endcase
      foreach (bytes[i])
         put_byte(bytes[i], i == bytes.size() - 1, drain && i == 0);
   endtask

   // sender: bursts with gaps, pausing where an item asks for a drained pipeline
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_proc
      logic        nxt_valid;
      logic [7:0]  nxt_byte;
      logic        nxt_end;
      pending_type p;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.buffer_end <= 1'b0;
      end else begin
         nxt_valid = req_bus.valid;
         nxt_byte = req_bus.data_byte;
         nxt_end = req_bus.buffer_end;
         if (req_bus.valid && req_bus.ready) begin
            decode_run_byte(req_bus.data_byte, req_bus.buffer_end);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain_first && expected_runs.size() != 0)) begin
               p = pending_bytes.pop_front();
               nxt_valid = 1'b1;
               nxt_byte = p.item.data_byte;
               nxt_end = p.item.buffer_end;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_bus.valid <= nxt_valid;
         req_bus.data_byte <= nxt_byte;
         req_bus.buffer_end <= nxt_end;
      end
   end

   // receiver: check each transaction, stall on its own flow pattern
   flow_type sink_mode  = FLOW_STEADY;
   int       seg_left   = 0;
   int       stall_tick = 0;
   int       hold_left  = 0;
   bit       hold_done  = 1'b0;

   always @(posedge clock) begin : sink_proc
      rsp_item_type want;
      logic         nxt_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_runs.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_CAP)
                  $display("%0t: unexpected transaction, expected none, actual kind %0d",
                           $time, rsp_bus.kind);
            end else begin
               want = expected_runs.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_bus.kind));
               check_field("cluster_count", want.cluster_count, rsp_bus.cluster_count);
               check_field("start_cluster", want.start_cluster, rsp_bus.start_cluster);
               check_field("sparse", 64'(want.sparse), 64'(rsp_bus.sparse));
               check_field("list_done", 64'(want.list_done), 64'(rsp_bus.list_done));
            end
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (seg_left == 0) begin
            sink_mode = flow_type'($urandom_range(0, 3));
            seg_left = $urandom_range(20, 120);
         end else begin
            seg_left--;
         end
         case (sink_mode)
            FLOW_STEADY: nxt_ready = 1'b1;
            FLOW_RANDOM: nxt_ready = 1'($urandom_range(0, 1));
            FLOW_SLOW:   nxt_ready = ($urandom_range(0, 3) == 0);
            default:     nxt_ready = (stall_tick % 7) < 4;
         endcase
         stall_tick++;
         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end
         rsp_bus.ready <= nxt_ready;
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stim_proc
      bit drain;
      reset = 1'b1;

      // negative offset wrapping the base, then a sparse run closing the buffer
      put_byte(8'h11, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h07, 1'b1);
      // end marker, then ignored bytes until the buffer end
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b1);
      // bad headers: offset size too big, zero length size, length size too big
      put_byte(8'hF1, 1'b0);
      put_byte(8'h3C, 1'b1);
      put_byte(8'h10, 1'b1);
      put_byte(8'h09, 1'b1);
      // truncations: header last, inside length, after length, inside offset
      put_byte(8'h21, 1'b1);
      put_byte(8'h12, 1'b0);
      put_byte(8'h01, 1'b1);
      put_byte(8'h11, 1'b0);
      put_byte(8'h01, 1'b1);
      put_byte(8'h21, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h05, 1'b1);

      drain = 1'b1;
      while (pending_bytes.size() < RANDOM_BYTES + 20) begin
         add_random_buffer(drain);
         drain = ($urandom_range(0, 19) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_bus.valid) begin
         fail_count++;
         $display("%0t: unexpected transaction, expected none, actual kind %0d",
                  $time, rsp_bus.kind);
      end
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/ntfsdr_pkg.sv
rtl/ntfsdr_if.sv
rtl/ntfsdr_in_reg.sv
rtl/ntfsdr_parser.sv
rtl/ntfsdr_out_reg.sv
rtl/ntfs_data_run_decoder_unit.sv
rtl/ntfsdr_checker.sv
tb/sv/tb_ntfs_data_run_decoder_unit.sv
